// ===== sv/mm4_pkg.sv =====
// Shared types and constants for the row-streamed 4x4 fixed-point matrix multiplier.
package mm4_pkg;

   localparam int WORD_W    = 32;
   localparam int FRAC_BITS = 16;
   localparam int NFIELD    = 4;
   localparam int PROD_W    = 2 * WORD_W;
   // Shifted products plus two bits of growth for a sum of up to four terms.
   localparam int SUM_W     = PROD_W - FRAC_BITS + 2;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_MUL  = 1'b1;

   typedef logic signed [WORD_W-1:0] word_type;

   localparam word_type SAT_MAX = 32'h7FFF_FFFF;
   localparam word_type SAT_MIN = 32'h8000_0000;

   typedef struct packed {
      logic       mode;
      logic [1:0] row_index;
      word_type   elem_0;
      word_type   elem_1;
      word_type   elem_2;
      word_type   elem_3;
   } req_type;

   typedef struct packed {
      logic [1:0] out_row;
      word_type   prod_0;
      word_type   prod_1;
      word_type   prod_2;
      word_type   prod_3;
      logic       overflow;
   } rsp_type;

   typedef struct packed {
      logic s1_en;
      logic s2_en;
   } pipe_ctl_type;

endpackage

// ===== sv/mm4_lane.sv =====
// One column lane: multiplies a row against one stored column and sums the shifted products.
module mm4_lane #(
   parameter int N = 4
) (
   input  logic                                  clock,
   input  mm4_pkg::pipe_ctl_type                 ctl,
   input  logic [N-1:0][mm4_pkg::WORD_W-1:0]     a_in,
   input  logic [N-1:0][mm4_pkg::WORD_W-1:0]     b_in,
   output logic signed [mm4_pkg::SUM_W-1:0]      sum_out
);

   logic signed [mm4_pkg::PROD_W-1:0] prod_in [N];
   logic signed [mm4_pkg::PROD_W-1:0] prod_ff [N];
   logic signed [mm4_pkg::SUM_W-1:0]  sum_in;
   logic signed [mm4_pkg::SUM_W-1:0]  sum_ff;

   always_comb begin
      for (int k = 0; k < N; k++) begin
         prod_in[k] = mm4_pkg::PROD_W'($signed(a_in[k])) * mm4_pkg::PROD_W'($signed(b_in[k]));
      end
   end

   // Arithmetic shift floors each product before the exact sum.
   always_comb begin
      sum_in = '0;
      for (int k = 0; k < N; k++) begin
         sum_in = sum_in + mm4_pkg::SUM_W'(prod_ff[k] >>> mm4_pkg::FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.s1_en) begin
         for (int k = 0; k < N; k++) begin
            prod_ff[k] <= prod_in[k];
         end
      end
      if (ctl.s2_en) begin
         sum_ff <= sum_in;
      end
   end

   assign sum_out = sum_ff;

endmodule

// ===== sv/mm4_merge.sv =====
// Merge stage: saturates the column sums, collects the overflow flag and holds the result beat.
module mm4_merge #(
   parameter int N = 4
) (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic [1:0]                           row_in,
   input  logic [N-1:0][mm4_pkg::SUM_W-1:0]     sums_in,
   output mm4_pkg::rsp_type                     rsp_out
);

   mm4_pkg::word_type   res [mm4_pkg::NFIELD];
   logic [mm4_pkg::NFIELD-1:0] sat;
   mm4_pkg::rsp_type    rsp_in;
   mm4_pkg::rsp_type    rsp_ff;

   for (genvar c = 0; c < mm4_pkg::NFIELD; c++) begin : g_col
      if (c < N) begin : g_live
         logic [mm4_pkg::SUM_W-1:0]          s;
         logic [mm4_pkg::SUM_W-mm4_pkg::WORD_W:0] hi;
         logic fits;
         assign s    = sums_in[c];
         assign hi   = s[mm4_pkg::SUM_W-1:mm4_pkg::WORD_W-1];
         // The sum fits when every bit from the word's sign bit upward agrees.
         assign fits = (&hi) | ~(|hi);
         assign res[c] = fits ? mm4_pkg::word_type'(s[mm4_pkg::WORD_W-1:0])
                              : (s[mm4_pkg::SUM_W-1] ? mm4_pkg::SAT_MIN : mm4_pkg::SAT_MAX);
         assign sat[c] = ~fits;
      end else begin : g_dead
         assign res[c] = '0;
         assign sat[c] = 1'b0;
      end
   end

   always_comb begin
      rsp_in          = '0;
      rsp_in.out_row  = row_in;
      rsp_in.prod_0   = res[0];
      rsp_in.prod_1   = res[1];
      rsp_in.prod_2   = res[2];
      rsp_in.prod_3   = res[3];
      rsp_in.overflow = |sat;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_out = rsp_ff;

endmodule

// ===== sv/matrix_multiply_4x4.sv =====
// Pipeline: a multiply row accepted into the product registers moves through the column
// sum registers and the saturated output register to rsp; rsp_ready can stall it.
// Throughput: one row per cycle unless rsp_ready stalls a full pipeline; all column
// lanes multiply in parallel, and load rows give no result.
// Reset: synchronous; clears the right-hand matrix store to zero and empties the pipeline.
module matrix_multiply_4x4 #(
   parameter int DIM = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mm4_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mm4_pkg::rsp_type rsp_data
);

   localparam int NE = (DIM < mm4_pkg::NFIELD) ? DIM : mm4_pkg::NFIELD;
   localparam int RW = (NE > 1) ? $clog2(NE) : 1;

   mm4_pkg::word_type elem [mm4_pkg::NFIELD];
   logic [mm4_pkg::WORD_W-1:0] b_ff [NE][NE];

   logic v1_ff, v2_ff, v3_ff;
   logic v1_in, v2_in, v3_in;
   logic [1:0] row_s1_ff, row_s2_ff;
   logic ready1, ready2, ready3;
   logic fire, row_ok, mul_fire, load_fire;
   mm4_pkg::pipe_ctl_type ctl;

   logic [NE-1:0][mm4_pkg::WORD_W-1:0] a_vec;
   logic [NE-1:0][mm4_pkg::WORD_W-1:0] b_col [NE];
   logic [NE-1:0][mm4_pkg::SUM_W-1:0]  sums;

   assign elem[0] = req_data.elem_0;
   assign elem[1] = req_data.elem_1;
   assign elem[2] = req_data.elem_2;
   assign elem[3] = req_data.elem_3;

   // Each stage moves on when it is empty or the stage after it moves on.
   assign ready3 = !v3_ff || rsp_ready;
   assign ready2 = !v2_ff || ready3;
   assign ready1 = !v1_ff || ready2;

   assign req_ready = ready1;
   assign fire      = req_valid && ready1;
   assign row_ok    = (int'(req_data.row_index) < NE);
   assign mul_fire  = fire && row_ok && (req_data.mode == mm4_pkg::MODE_MUL);
   assign load_fire = fire && row_ok && (req_data.mode == mm4_pkg::MODE_LOAD);

   assign v1_in = ready1 ? mul_fire : v1_ff;
   assign v2_in = ready2 ? v1_ff : v2_ff;
   assign v3_in = ready3 ? v2_ff : v3_ff;

   assign ctl.s1_en = ready1;
   assign ctl.s2_en = ready2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         row_s1_ff <= req_data.row_index;
      end
      if (ready2) begin
         row_s2_ff <= row_s1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NE; r++) begin
            for (int k = 0; k < NE; k++) begin
               b_ff[r][k] <= '0;
            end
         end
      end else if (load_fire) begin
         for (int k = 0; k < NE; k++) begin
            b_ff[req_data.row_index[RW-1:0]][k] <= elem[k];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < NE; k++) begin
         a_vec[k] = elem[k];
         for (int c = 0; c < NE; c++) begin
            b_col[c][k] = b_ff[k][c];
         end
      end
   end

   for (genvar c = 0; c < NE; c++) begin : g_lane
      mm4_lane #(.N(NE)) u_lane (
         .clock   (clock),
         .ctl     (ctl),
         .a_in    (a_vec),
         .b_in    (b_col[c]),
         .sum_out (sums[c])
      );
   end

   mm4_merge #(.N(NE)) u_merge (
      .clock   (clock),
      .en      (ready3),
      .row_in  (row_s2_ff),
      .sums_in (sums),
      .rsp_out (rsp_data)
   );

   assign rsp_valid = v3_ff;

endmodule

// ===== sv/mm4_checker.sv =====
// Port-level checks for the matrix multiplier and their binding to the top level.
module mm4_checker #(
   parameter int DIM = 4
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input mm4_pkg::rsp_type rsp_data
);

   // A stalled result beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // The input side only stalls when the output register is full and held.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled with room in the pipeline");

   a_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overflow |->
         rsp_data.prod_0 == mm4_pkg::SAT_MAX || rsp_data.prod_0 == mm4_pkg::SAT_MIN ||
         rsp_data.prod_1 == mm4_pkg::SAT_MAX || rsp_data.prod_1 == mm4_pkg::SAT_MIN ||
         rsp_data.prod_2 == mm4_pkg::SAT_MAX || rsp_data.prod_2 == mm4_pkg::SAT_MIN ||
         rsp_data.prod_3 == mm4_pkg::SAT_MAX || rsp_data.prod_3 == mm4_pkg::SAT_MIN)
      else $error("overflow flagged without a saturated column");

   a_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_data.out_row) < DIM)
      else $error("result row outside the matrix");

endmodule

bind matrix_multiply_4x4 mm4_checker #(.DIM(DIM)) u_mm4_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
